// File: rtl/core/tdrw_pkg.sv
// ----------------------------------------------------------------------------
// tdrw_pkg
// shared widths, defaults and the queue word of the transmit descriptor walker
// ----------------------------------------------------------------------------
package tdrw_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned LEN_W            = 16;
  localparam int unsigned OUT_W            = 12;
  localparam int unsigned MAX_FRAME_DEF    = 2048;
  localparam int unsigned DESC_BYTES_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  // descriptor word after classification
  typedef struct packed {
    logic              stopped;
    logic              last;
    logic              wrap;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic              stopped;
    logic [ADDR_W-1:0] dma_addr;
    logic [OUT_W-1:0]  dma_len;
    logic              writeback;
    logic              frame_done;
    logic [OUT_W-1:0]  frame_bytes;
    logic              int_babble;
    logic              int_tx_frame;
    logic              int_tx_buffer;
    logic [ADDR_W-1:0] next_desc_addr;
  } res_t;

endpackage

// File: rtl/core/tdrw_if.sv
// ----------------------------------------------------------------------------
// tdrw_if
// valid/ready channels for fetched descriptors and for walker results
// ----------------------------------------------------------------------------
interface tdrw_desc_if;
  logic        valid;
  logic        ready;
  logic        desc_ready;
  logic        desc_last;
  logic        desc_wrap;
  logic [15:0] desc_length;
  logic [31:0] buffer_addr;

  modport source (
    output valid, desc_ready, desc_last, desc_wrap, desc_length, buffer_addr,
    input  ready
  );
  modport sink (
    input  valid, desc_ready, desc_last, desc_wrap, desc_length, buffer_addr,
    output ready
  );
endinterface

interface tdrw_res_if;
  logic        valid;
  logic        ready;
  logic        stopped;
  logic [31:0] dma_addr;
  logic [11:0] dma_len;
  logic        writeback;
  logic        frame_done;
  logic [11:0] frame_bytes;
  logic        int_babble;
  logic        int_tx_frame;
  logic        int_tx_buffer;
  logic [31:0] next_desc_addr;

  modport source (
    output valid, stopped, dma_addr, dma_len, writeback, frame_done, frame_bytes,
           int_babble, int_tx_frame, int_tx_buffer, next_desc_addr,
    input  ready
  );
  modport sink (
    input  valid, stopped, dma_addr, dma_len, writeback, frame_done, frame_bytes,
           int_babble, int_tx_frame, int_tx_buffer, next_desc_addr,
    output ready
  );
endinterface

// File: rtl/core/tx_descriptor_ring_walker.sv
// ----------------------------------------------------------------------------
// tx_descriptor_ring_walker
// transmit descriptor ring walker: clip, dma read, writeback and frame events
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  desc_i    in   valid/ready        fetched descriptor
//  res_o     out  valid/ready        dma, writeback and event flags
//  cfg       in   cfg_we_i only      ring base address
//
//  one descriptor per cycle while the queue is not full; a result passes through
//  a queue slot and then the output register of the back end
//  desc_i.ready follows only the queue fill level, so input is taken while a
//  result waits; a stalled res_o backs up into the queue
//  reset clears the walk address, the byte count and the ring base
// ----------------------------------------------------------------------------
module tx_descriptor_ring_walker #(
  parameter int unsigned MaxFrame   = tdrw_pkg::MAX_FRAME_DEF,
  parameter int unsigned DescBytes  = tdrw_pkg::DESC_BYTES_DEF,
  parameter int unsigned QueueDepth = tdrw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tdrw_pkg::ADDR_W-1:0] cfg_wdata_i,
  tdrw_desc_if.sink                   desc_i,
  tdrw_res_if.source                  res_o
);
  import tdrw_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_wword, q_rword;

  tdrw_front #(
    .MaxFrame (MaxFrame)
  ) u_front (
    .desc_i   (desc_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_word_o (q_wword)
  );

  tdrw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wword),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rword)
  );

  tdrw_back #(
    .MaxFrame  (MaxFrame),
    .DescBytes (DescBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_word_i    (q_rword),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

// File: rtl/core/tdrw_front.sv
// ----------------------------------------------------------------------------
// tdrw_front
// takes descriptor words, classifies them and saturates the length
// ----------------------------------------------------------------------------
module tdrw_front #(
  parameter int unsigned MaxFrame = tdrw_pkg::MAX_FRAME_DEF
) (
  tdrw_desc_if.sink        desc_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tdrw_pkg::cmd_t   q_word_o
);
  import tdrw_pkg::*;

  localparam logic [LEN_W-1:0] LenSat = LEN_W'(MaxFrame + 1);

  assign desc_i.ready = !q_full_i;
  assign q_push_o     = desc_i.valid && !q_full_i;

  always_comb begin
    q_word_o.stopped = !desc_i.desc_ready;
    q_word_o.last    = desc_i.desc_last;
    q_word_o.wrap    = desc_i.desc_wrap;
    q_word_o.addr    = desc_i.buffer_addr;
    // anything above the frame limit behaves the same, keep it narrow
    if (desc_i.desc_length > LenSat) begin
      q_word_o.length = LenSat;
    end else begin
      q_word_o.length = desc_i.desc_length;
    end
  end

endmodule

// File: rtl/core/tdrw_queue.sv
// ----------------------------------------------------------------------------
// tdrw_queue
// short fifo between the front and the back of the walker
// ----------------------------------------------------------------------------
module tdrw_queue #(
  parameter int unsigned Depth = tdrw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tdrw_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tdrw_pkg::cmd_t rdata_o
);
  import tdrw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> !full_o)
    else $error("queue full after pop");

endmodule

// File: rtl/core/tdrw_back.sv
// ----------------------------------------------------------------------------
// tdrw_back
// walks the ring: clips lengths, counts frame bytes, steps the address
// ----------------------------------------------------------------------------
module tdrw_back #(
  parameter int unsigned MaxFrame  = tdrw_pkg::MAX_FRAME_DEF,
  parameter int unsigned DescBytes = tdrw_pkg::DESC_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdrw_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          q_valid_i,
  input  tdrw_pkg::cmd_t                q_word_i,
  output logic                          q_pop_o,
  tdrw_res_if.source                    res_o
);
  import tdrw_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned LenW = $clog2(MaxFrame + 2);
  localparam int unsigned SumW = LenW + 1;

  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [CntW-1:0]   gath_q, gath_d;
  logic              out_vld_q;
  res_t              out_q, out_d;

  logic [LenW-1:0]   len_n;
  logic [SumW-1:0]   sum;
  logic              over;
  logic [CntW-1:0]   len_eff;
  logic [CntW-1:0]   gath_new;
  logic [ADDR_W-1:0] next_addr;

  assign q_pop_o = q_valid_i && (!out_vld_q || res_o.ready);

  assign len_n     = q_word_i.length[LenW-1:0];
  assign sum       = SumW'(gath_q) + SumW'(len_n);
  assign over      = (sum > SumW'(MaxFrame));
  assign len_eff   = over ? CntW'(CntW'(MaxFrame) - gath_q) : CntW'(len_n);
  assign gath_new  = gath_q + len_eff;
  assign next_addr = q_word_i.wrap ? base_q : cur_q + ADDR_W'(DescBytes);

  always_comb begin
    cur_d  = cur_q;
    gath_d = gath_q;
    out_d  = '0;
    if (q_word_i.stopped) begin
      out_d.stopped        = 1'b1;
      out_d.next_desc_addr = cur_q;
    end else begin
      out_d.dma_addr       = q_word_i.addr;
      out_d.dma_len        = OUT_W'(len_eff);
      out_d.writeback      = 1'b1;
      out_d.int_babble     = over;
      out_d.int_tx_buffer  = 1'b1;
      out_d.next_desc_addr = next_addr;
      cur_d                = next_addr;
      if (q_word_i.last) begin
        out_d.frame_done   = 1'b1;
        out_d.int_tx_frame = 1'b1;
        out_d.frame_bytes  = OUT_W'(gath_new);
        gath_d             = '0;
      end else begin
        gath_d             = gath_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      cur_q     <= '0;
      gath_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        cur_q     <= cur_d;
        gath_q    <= gath_d;
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.stopped        = out_q.stopped;
  assign res_o.dma_addr       = out_q.dma_addr;
  assign res_o.dma_len        = out_q.dma_len;
  assign res_o.writeback      = out_q.writeback;
  assign res_o.frame_done     = out_q.frame_done;
  assign res_o.frame_bytes    = out_q.frame_bytes;
  assign res_o.int_babble     = out_q.int_babble;
  assign res_o.int_tx_frame   = out_q.int_tx_frame;
  assign res_o.int_tx_buffer  = out_q.int_tx_buffer;
  assign res_o.next_desc_addr = out_q.next_desc_addr;

  a_gath_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gath_q <= CntW'(MaxFrame))
    else $error("gathered bytes above frame limit");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_word_i.stopped && q_word_i.last) |=> (gath_q == '0))
    else $error("byte count not cleared after frame");

  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_word_i.stopped) |=> ($stable(cur_q) && $stable(gath_q)))
    else $error("walk state moved on a stopped descriptor");

endmodule

// File: tb/tx_descriptor_ring_walker_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_descriptor_ring_walker_chk
// Watches the descriptor and result channels of the ring walker. It predicts
// each result from its own copy of the walk address, the open frame byte count
// and the ring base. Every result that the walker hands out is checked field
// by field against the oldest prediction. It counts the mismatches and a few
// coverage figures for the testbench top.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_walker_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  tdrw_desc_if        desc_i,
  tdrw_res_if         res_i,
  output int          fail_cnt_o,
  output int          due_cnt_o,
  output int          word_cnt_o,
  output int          result_cnt_o,
  output int          stopped_cnt_o,
  output int          clip_cnt_o,
  output int          frame_cnt_o,
  output int          wrap_cnt_o
);
  import tdrw_pkg::*;

  localparam int unsigned FrameLimit = MAX_FRAME_DEF;
  localparam int unsigned DescStep   = DESC_BYTES_DEF;

  logic [31:0] walk_addr;
  logic [31:0] ring_base;
  int unsigned frame_fill;
  res_t        walk_due_q[$];
  int          fails, words, results, stops, clips, frames, wraps;

  function automatic res_t walk_descriptor(input logic rdy, input logic last,
                                           input logic wrap, input logic [15:0] len,
                                           input logic [31:0] baddr);
    res_t        r;
    int unsigned take;
    r = '0;
    if (!rdy) begin
      r.stopped        = 1'b1;
      r.next_desc_addr = walk_addr;
      return r;
    end
    take = len;
    if (frame_fill + take > FrameLimit) begin
      take         = FrameLimit - frame_fill;
      r.int_babble = 1'b1;
    end
    frame_fill      = frame_fill + take;
    r.dma_addr      = baddr;
    r.dma_len       = take[11:0];
    r.writeback     = 1'b1;
    r.int_tx_buffer = 1'b1;
    if (last) begin
      r.frame_done   = 1'b1;
      r.int_tx_frame = 1'b1;
      r.frame_bytes  = frame_fill[11:0];
      frame_fill     = 0;
    end
    walk_addr        = wrap ? ring_base : walk_addr + DescStep;
    r.next_desc_addr = walk_addr;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      walk_addr  = '0;
      ring_base  = '0;
      frame_fill = 0;
      walk_due_q.delete();
      fails = 0; words = 0; results = 0; stops = 0;
      clips = 0; frames = 0; wraps = 0;
    end else begin
      if (cfg_we_i) begin
        ring_base = cfg_wdata_i;
      end
      // result side first, a word taken this edge cannot already be out
      if (res_i.valid && res_i.ready) begin
        results++;
        if (walk_due_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got next_desc_addr %h",
                   $time, res_i.next_desc_addr);
        end else begin
          exp_r = walk_due_q.pop_front();
          check_field("stopped",        32'(exp_r.stopped),        32'(res_i.stopped));
          check_field("dma_addr",       exp_r.dma_addr,            res_i.dma_addr);
          check_field("dma_len",        32'(exp_r.dma_len),        32'(res_i.dma_len));
          check_field("writeback",      32'(exp_r.writeback),      32'(res_i.writeback));
          check_field("frame_done",     32'(exp_r.frame_done),     32'(res_i.frame_done));
          check_field("frame_bytes",    32'(exp_r.frame_bytes),    32'(res_i.frame_bytes));
          check_field("int_babble",     32'(exp_r.int_babble),     32'(res_i.int_babble));
          check_field("int_tx_frame",   32'(exp_r.int_tx_frame),   32'(res_i.int_tx_frame));
          check_field("int_tx_buffer",  32'(exp_r.int_tx_buffer),  32'(res_i.int_tx_buffer));
          check_field("next_desc_addr", exp_r.next_desc_addr,      res_i.next_desc_addr);
        end
      end
      if (desc_i.valid && desc_i.ready) begin
        words++;
        exp_r = walk_descriptor(desc_i.desc_ready, desc_i.desc_last, desc_i.desc_wrap,
                                desc_i.desc_length, desc_i.buffer_addr);
        if (exp_r.stopped) stops++;
        if (exp_r.int_babble) clips++;
        if (exp_r.frame_done) frames++;
        if (desc_i.desc_ready && desc_i.desc_wrap) wraps++;
        walk_due_q.push_back(exp_r);
      end
    end
    fail_cnt_o    <= fails;
    due_cnt_o     <= walk_due_q.size();
    word_cnt_o    <= words;
    result_cnt_o  <= results;
    stopped_cnt_o <= stops;
    clip_cnt_o    <= clips;
    frame_cnt_o   <= frames;
    wrap_cnt_o    <= wraps;
  end

endmodule

// File: tb/tx_descriptor_ring_walker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_descriptor_ring_walker_tb
// Drives fetched descriptors into the ring walker and drains its results with
// random idle bursts on both sides and one long result stall that backs the
// walker up. A directed opening covers stopped descriptors, clipping at the
// frame limit, zero length frames, wrap to the ring base and address
// overflow. Random frames follow under several ring base settings. The
// checker beside the walker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_walker_tb;
  import tdrw_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomWords = 1750;
  localparam int LongHold    = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int fail_cnt, due_cnt, word_cnt, result_cnt;
  int stopped_cnt, clip_cnt, frame_cnt, wrap_cnt;
  int gap_pct;
  int stall_pct;
  int sent;

  tdrw_desc_if desc_if ();
  tdrw_res_if  res_if ();

  tx_descriptor_ring_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .desc_i      (desc_if),
    .res_o       (res_if)
  );

  tx_descriptor_ring_walker_chk chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .desc_i        (desc_if),
    .res_i         (res_if),
    .fail_cnt_o    (fail_cnt),
    .due_cnt_o     (due_cnt),
    .word_cnt_o    (word_cnt),
    .result_cnt_o  (result_cnt),
    .stopped_cnt_o (stopped_cnt),
    .clip_cnt_o    (clip_cnt),
    .frame_cnt_o   (frame_cnt),
    .wrap_cnt_o    (wrap_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still due", CycleLimit, due_cnt);
    $display("== FAIL ==");
    $finish;
  end

  // result side: short random stalls plus one long hold-off to fill the walker
  initial begin
    int  hold;
    bit  long_done;
    hold      = 0;
    long_done = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!long_done && result_cnt >= 400) begin
        hold      = LongHold;
        long_done = 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 4);
      end
      res_if.ready <= (hold == 0);
    end
  end

  task automatic offer_desc(input logic rdy, input logic last, input logic wrap,
                            input logic [15:0] len, input logic [31:0] baddr);
    if ($urandom_range(0, 99) < gap_pct) begin
      desc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    desc_if.valid       <= 1'b1;
    desc_if.desc_ready  <= rdy;
    desc_if.desc_last   <= last;
    desc_if.desc_wrap   <= wrap;
    desc_if.desc_length <= len;
    desc_if.buffer_addr <= baddr;
    @(posedge clk_i);
    while (!desc_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain_walker();
    desc_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ring_base(input logic [31:0] base);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // a frame of one to four buffers, with the odd stopped fetch retried
  task automatic send_random_frame();
    int          nbuf;
    logic        last;
    logic        wrap;
    logic [15:0] len;
    logic [31:0] baddr;
    nbuf = $urandom_range(1, 4);
    for (int i = 0; i < nbuf; i++) begin
      case ($urandom_range(0, 9))
        0:       len = 16'($urandom_range(0, 65535));
        1:       len = 16'($urandom_range(1500, 2100));
        2:       len = 16'd0;
        default: len = 16'($urandom_range(0, 700));
      endcase
      last  = (i == nbuf - 1);
      if ($urandom_range(0, 19) == 0) last = ~last;
      wrap  = ($urandom_range(0, 7) == 0);
      baddr = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        offer_desc(1'b0, 1'($urandom), 1'($urandom), 16'($urandom), $urandom);
      end
      offer_desc(1'b1, last, wrap, len, baddr);
    end
  endtask

  initial begin
    logic [31:0] bases[4];
    int          target;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    desc_if.valid       <= 1'b0;
    desc_if.desc_ready  <= 1'b0;
    desc_if.desc_last   <= 1'b0;
    desc_if.desc_wrap   <= 1'b0;
    desc_if.desc_length <= '0;
    desc_if.buffer_addr <= '0;
    gap_pct   = 20;
    stall_pct = 20;
    sent      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening
    offer_desc(1'b0, 1'b1, 1'b1, 16'hffff, 32'hffff_ffff);
    drain_walker();
    write_ring_base(32'h1000_0000);
    offer_desc(1'b1, 1'b0, 1'b0, 16'd100,   32'h0000_0000);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd0,     32'hffff_ffff);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd0,     32'haaaa_aaaa);
    offer_desc(1'b1, 1'b0, 1'b0, 16'hffff,  32'h5555_5555);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd5,     32'h0000_0001);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd2048,  32'h8000_0000);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd2049,  32'h7fff_ffff);
    offer_desc(1'b1, 1'b0, 1'b0, 16'd1000,  32'h1234_5678);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd1048,  32'h8765_4321);
    offer_desc(1'b1, 1'b0, 1'b1, 16'd64,    32'h0000_1000);
    offer_desc(1'b0, 1'b0, 1'b1, 16'd64,    32'h0000_1000);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd64,    32'h0000_1000);
    offer_desc(1'b1, 1'b0, 1'b0, 16'h8000,  32'hdead_beef);
    offer_desc(1'b0, 1'b1, 1'b0, 16'h0001,  32'h0000_0000);
    offer_desc(1'b1, 1'b1, 1'b1, 16'h0fff,  32'hcafe_f00d);
    drain_walker();
    write_ring_base(32'hffff_fff8);
    offer_desc(1'b1, 1'b0, 1'b1, 16'd1,     32'h0000_0010);
    offer_desc(1'b1, 1'b0, 1'b0, 16'd2,     32'h0000_0020);
    offer_desc(1'b1, 1'b1, 1'b0, 16'd3,     32'h0000_0030);
    offer_desc(1'b0, 1'b0, 1'b0, 16'd0,     32'h0000_0000);
    drain_walker();

    // random frames under several ring bases, no idling in the last one
    bases[0] = $urandom;
    bases[1] = 32'hffff_ffff;
    bases[2] = 32'hffff_fff8;
    bases[3] = 32'h0000_0000;
    target   = sent;
    for (int ph = 0; ph < 4; ph++) begin
      write_ring_base(bases[ph]);
      target = target + RandomWords / 4;
      while (sent < target) begin
        if (ph == 3) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          gap_pct   = 20 * $urandom_range(0, 2);
          stall_pct = 20 * $urandom_range(0, 2);
        end
        send_random_frame();
      end
      drain_walker();
    end

    $display("covered %0d descriptors and %0d results: %0d stopped, %0d clipped",
             word_cnt, result_cnt, stopped_cnt, clip_cnt);
    $display("%0d frames, %0d ring wraps, six ring base settings, one long result stall",
             frame_cnt, wrap_cnt);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
